[sv/gcr_pkg.sv]
// shared widths, command and status codes for the genome coordinate resolver
package gcr_pkg;

    // default table depth
    localparam int MAX_CHROMOSOMES = 256;

    // field widths
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;
    localparam int LEN_W    = 32;
    localparam int COORD_W  = 41;
    localparam int MLEN_W   = 8;
    localparam int STATUS_W = 2;

    typedef logic [LEN_W-1:0]   length_t;
    typedef logic [COORD_W-1:0] coord_t;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PAST_END = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CROSSES  = 2'd2;

endpackage

[sv/gcr_item_if.sv]
// input channel: load and resolve items
interface gcr_item_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [gcr_pkg::INDEX_W-1:0] table_index;
    gcr_pkg::length_t            chromosome_length;
    gcr_pkg::coord_t             absolute_coordinate;
    logic [gcr_pkg::MLEN_W-1:0]  match_length;

    modport source (
        output valid, command, table_index, chromosome_length,
               absolute_coordinate, match_length,
        input  ready
    );

    modport sink (
        input  valid, command, table_index, chromosome_length,
               absolute_coordinate, match_length,
        output ready
    );
endinterface

[sv/gcr_result_if.sv]
// output channel: resolved coordinates
interface gcr_result_if;
    logic                         valid;
    logic                         ready;
    logic [gcr_pkg::STATUS_W-1:0] status;
    logic [gcr_pkg::INDEX_W-1:0]  chromosome_index;
    gcr_pkg::length_t             match_start;
    logic                         minus_strand;

    modport source (
        output valid, status, chromosome_index, match_start, minus_strand,
        input  ready
    );

    modport sink (
        input  valid, status, chromosome_index, match_start, minus_strand,
        output ready
    );
endinterface

[sv/genome_coordinate_resolver_top.sv]
// Genome coordinate resolver: a table of chromosome lengths in a single-port-read
// memory (one write, one registered read per cycle) and a small sequencer that walks
// it with one shared 41-bit subtract and compare. A load beat is taken from the idle
// state, which it does not leave. A resolve beat walks the smaller of chromosome_count
// and MAX_CHROMOSOMES entries: reads run one entry ahead through the registered memory
// read, each entry goes through the subtract and compare unit, and the result is then
// formed once the previous result has left the output register; the walk ends early
// at the entry that holds the offset, and with no entries in use a resolve goes
// straight to forming the result. The input is not ready during a walk; a finished
// result waits in the output register while the next beat is taken. The user must
// write chromosome_count through cfg_we / cfg_data only while the block is idle; the
// block itself does not enforce it. Entries are not cleared at reset: a resolve must
// only walk over entries that were loaded.
module genome_coordinate_resolver_top #(
    parameter int MAX_CHROMOSOMES = gcr_pkg::MAX_CHROMOSOMES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gcr_item_if.sink                    item,
    gcr_result_if.source                result,
    input  logic                        cfg_we,
    input  logic [gcr_pkg::COUNT_W-1:0] cfg_data
);

    localparam int AW = (MAX_CHROMOSOMES > 1) ? $clog2(MAX_CHROMOSOMES) : 1;
    localparam int CW = $clog2(MAX_CHROMOSOMES + 1);
    localparam int OW = gcr_pkg::COORD_W;
    localparam int LW = gcr_pkg::LEN_W;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

    state_t                       state_reg, state_next;
    logic [gcr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [OW-1:0]                off_reg, off_next;
    logic                         minus_reg, minus_next;
    logic [gcr_pkg::MLEN_W-1:0]   mlen_reg, mlen_next;
    logic [CW-1:0]                used_reg, used_next;
    logic [CW-1:0]                issue_reg, issue_next;
    logic [CW-1:0]                chk_reg, chk_next;
    logic                         data_vld_reg, data_vld_next;
    logic                         found_reg, found_next;
    logic [CW-1:0]                which_reg, which_next;
    gcr_pkg::length_t             chrlen_reg, chrlen_next;
    logic                         res_valid_reg, res_valid_next;
    logic [gcr_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [gcr_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;
    gcr_pkg::length_t             res_start_reg, res_start_next;
    logic                         res_minus_reg, res_minus_next;

    gcr_pkg::length_t             table_mem [MAX_CHROMOSOMES];
    gcr_pkg::length_t             rd_data_reg;

    logic                         in_fire;
    logic                         res_fire;
    logic                         mem_we;
    logic                         coord_neg;
    logic [OW-1:0]                coord_mag;
    logic [CW-1:0]                used_calc;
    logic [CW-1:0]                chk_inc;
    logic                         fits;
    logic [OW-1:0]                off_sub;
    logic [LW-1:0]                off_lo;
    logic [LW+1:0]                plus_sum;
    logic [LW+1:0]                plus_start;
    logic                         plus_cross;
    logic [LW:0]                  minus_end;
    logic                         minus_cross;
    gcr_pkg::length_t             minus_start;

    // handshakes
    assign item.ready = (state_reg == S_IDLE);
    assign in_fire    = item.valid && item.ready;
    assign res_fire   = result.valid && result.ready;

    assign result.valid            = res_valid_reg;
    assign result.status           = res_status_reg;
    assign result.chromosome_index = res_index_reg;
    assign result.match_start      = res_start_reg;
    assign result.minus_strand     = res_minus_reg;

    // length table: one write port for loads, one registered read port for the walk
    assign mem_we = in_fire && (item.command == gcr_pkg::CMD_LOAD)
                    && (32'(item.table_index) < 32'(MAX_CHROMOSOMES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[AW'(item.table_index)] <= item.chromosome_length;
        end
        rd_data_reg <= table_mem[issue_reg[AW-1:0]];
    end

    // magnitude and strand of the incoming coordinate
    assign coord_neg = item.absolute_coordinate[OW-1];
    assign coord_mag = coord_neg ? (~item.absolute_coordinate + OW'(1))
                                 : item.absolute_coordinate;

    // entries actually walked
    assign used_calc = (32'(count_reg) > 32'(MAX_CHROMOSOMES)) ? CW'(MAX_CHROMOSOMES)
                                                               : CW'(count_reg);

    // shared subtract and compare unit
    assign fits    = off_reg < {{(OW - LW){1'b0}}, rd_data_reg};
    assign off_sub = off_reg - {{(OW - LW){1'b0}}, rd_data_reg};
    assign chk_inc = chk_reg + CW'(1);

    // match bounds, offset known to fit 32 bits once found
    assign off_lo      = off_reg[LW-1:0];
    assign plus_sum    = {2'b00, off_lo} + (LW + 2)'(2);
    assign plus_cross  = plus_sum < (LW + 2)'(mlen_reg);
    assign plus_start  = plus_sum - (LW + 2)'(mlen_reg);
    assign minus_end   = {1'b0, off_lo} + (LW + 1)'(mlen_reg);
    assign minus_cross = minus_end > {1'b0, chrlen_reg};
    assign minus_start = off_lo + LW'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        off_next        = off_reg;
        minus_next      = minus_reg;
        mlen_next       = mlen_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        chk_next        = chk_reg;
        data_vld_next   = 1'b0;
        found_next      = found_reg;
        which_next      = which_reg;
        chrlen_next     = chrlen_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_start_next  = res_start_reg;
        res_minus_next  = res_minus_reg;

        if (cfg_we)
        begin
            count_next = cfg_data;
        end

        if (res_fire)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (item.command == gcr_pkg::CMD_RESOLVE))
                begin
                    off_next   = coord_mag;
                    minus_next = coord_neg;
                    mlen_next  = item.match_length;
                    used_next  = used_calc;
                    issue_next = '0;
                    chk_next   = '0;
                    found_next = 1'b0;
                    state_next = (used_calc == '0) ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                // keep reads one entry ahead of the compare
                if (issue_reg < used_reg)
                begin
                    issue_next    = issue_reg + CW'(1);
                    data_vld_next = 1'b1;
                end
                if (data_vld_reg)
                begin
                    if (fits)
                    begin
                        found_next    = 1'b1;
                        which_next    = chk_reg;
                        chrlen_next   = rd_data_reg;
                        data_vld_next = 1'b0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        off_next = off_sub;
                        chk_next = chk_inc;
                        if (chk_inc == used_reg)
                        begin
                            data_vld_next = 1'b0;
                            state_next    = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                // form the result once the output register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = gcr_pkg::ST_OK;
                    res_index_next  = '0;
                    res_start_next  = '0;
                    res_minus_next  = 1'b0;
                    if (!found_reg)
                    begin
                        res_status_next = gcr_pkg::ST_PAST_END;
                    end
                    else if (minus_reg ? minus_cross : plus_cross)
                    begin
                        res_status_next = gcr_pkg::ST_CROSSES;
                    end
                    else
                    begin
                        res_index_next = gcr_pkg::INDEX_W'(which_reg);
                        res_start_next = minus_reg ? minus_start : plus_start[LW-1:0];
                        res_minus_next = minus_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            off_reg        <= '0;
            minus_reg      <= 1'b0;
            mlen_reg       <= '0;
            used_reg       <= '0;
            issue_reg      <= '0;
            chk_reg        <= '0;
            data_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            which_reg      <= '0;
            chrlen_reg     <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= gcr_pkg::ST_OK;
            res_index_reg  <= '0;
            res_start_reg  <= '0;
            res_minus_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            off_reg        <= off_next;
            minus_reg      <= minus_next;
            mlen_reg       <= mlen_next;
            used_reg       <= used_next;
            issue_reg      <= issue_next;
            chk_reg        <= chk_next;
            data_vld_reg   <= data_vld_next;
            found_reg      <= found_next;
            which_reg      <= which_next;
            chrlen_reg     <= chrlen_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_index_reg  <= res_index_next;
            res_start_reg  <= res_start_next;
            res_minus_reg  <= res_minus_next;
        end
    end

    // a new result only appears out of the result-forming state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside of result state");

    // failed resolves carry no position
    a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != gcr_pkg::ST_OK)) |->
        ((result.chromosome_index == '0) && (result.match_start == '0)
         && !result.minus_strand))
        else $error("failed resolve carries nonzero fields");

    // read data belongs to the entry under compare, one read ahead
    a_read_lead: assert property (@(posedge clk) disable iff (!rst_n)
        data_vld_reg |-> ((state_reg == S_WALK) && (issue_reg == chk_inc)))
        else $error("table read out of step with compare");

    // the walk never passes the entries in use
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (chk_reg < used_reg))
        else $error("walk beyond entries in use");

endmodule

[tb/sv/tb_genome_coordinate_resolver_top.sv]
// self-checking testbench for the genome coordinate resolver: directed and random load/resolve beats
`timescale 1ns / 1ps

module tb_genome_coordinate_resolver_top;
    import gcr_pkg::*;

    // longest walk plus memory read and result register, with margin
    localparam int SETTLE_CYCLES = MAX_CHROMOSOMES + 8;
    localparam int DRAIN_LIMIT = 4000;
    localparam int PHASE_BEATS = 110;
    // magnitude of the most negative coordinate the signed field holds
    localparam longint COORD_SPAN = longint'(1) << (COORD_W - 1);
    // first position of entry 3 in the directed table
    localparam longint ENTRY3_BASE = 64'd10 + 64'hFFFF_FFFF;

    typedef struct {
        logic                command;
        logic [INDEX_W-1:0]  table_index;
        length_t             chromosome_length;
        coord_t              absolute_coordinate;
        logic [MLEN_W-1:0]   match_length;
    } gcr_beat_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  chromosome_index;
        length_t             match_start;
        logic                minus_strand;
    } placement_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    gcr_item_if   item_bus();
    gcr_result_if result_bus();

    genome_coordinate_resolver_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_bus),
        .result   (result_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    gcr_beat_t  beat_backlog[$];
    placement_t expected_placements[$];
    int         mismatch_count;

    // predictor copy of the length table and entry count
    length_t            chrom_lengths[MAX_CHROMOSOMES];
    logic [COUNT_W-1:0] chrom_count;

    // stimulus-side view of the table, used to aim coordinates
    length_t plan_lengths[MAX_CHROMOSOMES];
    bit      plan_loaded[MAX_CHROMOSOMES];

    int phase_counts[12] = '{1, 256, 4, 511, 12, 2, 300, 7, 64, 0, 30, 3};

    // driver state
    bit        drv_active;
    int        drv_wait;
    bit        drv_gaps_on = 1;
    gcr_beat_t drv_beat;

    // monitor state
    bit         snk_ready;
    int         snk_stall;
    bit         snk_stalls_on = 1;
    placement_t seen;
    placement_t want;

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic string show(placement_t p);
        return $sformatf("status=%0d index=%0d start=%0d minus=%0d",
                         p.status, p.chromosome_index, p.match_start, p.minus_strand);
    endfunction

    // walk the table for one resolve beat and place the match
    function automatic placement_t locate_match(coord_t coord, logic [MLEN_W-1:0] mlen);
        placement_t r;
        longint     off;
        longint     len;
        longint     mlen_l;
        longint     start_pos;
        longint     end_pos;
        int         used;
        bit         minus_s;
        r.status = ST_PAST_END;
        r.chromosome_index = '0;
        r.match_start = '0;
        r.minus_strand = 1'b0;
        mlen_l = longint'(mlen);
        minus_s = coord[COORD_W-1];
        off = minus_s ? ((longint'(1) << COORD_W) - longint'(coord)) : longint'(coord);
        used = (chrom_count > MAX_CHROMOSOMES) ? MAX_CHROMOSOMES : int'(chrom_count);
        for (int i = 0; i < used; i++)
        begin
            len = longint'(chrom_lengths[i]);
            if (off < len)
            begin
                // plus strand offset is the match end, minus strand offset is its start
                if (minus_s)
                begin
                    start_pos = off + 1;
                    end_pos = off + mlen_l;
                end
                else
                begin
                    end_pos = off + 1;
                    start_pos = off - mlen_l + 2;
                end
                if (start_pos < 0 || end_pos > len)
                    r.status = ST_CROSSES;
                else
                begin
                    r.status = ST_OK;
                    r.chromosome_index = i[INDEX_W-1:0];
                    r.match_start = start_pos[LEN_W-1:0];
                    r.minus_strand = minus_s;
                end
                return r;
            end
            off -= len;
        end
        return r;
    endfunction

    // update the predictor with one accepted beat
    function automatic void absorb_beat(gcr_beat_t b);
        if (b.command == CMD_LOAD)
            chrom_lengths[b.table_index] = b.chromosome_length;
        else
            expected_placements.push_back(locate_match(b.absolute_coordinate, b.match_length));
    endfunction

    function automatic length_t draw_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return length_t'($urandom);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 300);
            default: return length_t'($urandom_range(1, 600));
        endcase
    endfunction

    function automatic logic [MLEN_W-1:0] draw_match_length();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return 8'd1;
            default: return MLEN_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void push_load(int idx, length_t len);
        gcr_beat_t b;
        b.command = CMD_LOAD;
        b.table_index = idx[INDEX_W-1:0];
        b.chromosome_length = len;
        b.absolute_coordinate = coord_t'({$urandom, $urandom});
        b.match_length = MLEN_W'($urandom);
        plan_lengths[idx] = len;
        plan_loaded[idx] = 1;
        beat_backlog.push_back(b);
    endfunction

    function automatic void push_resolve_coord(coord_t coord, logic [MLEN_W-1:0] mlen);
        gcr_beat_t b;
        b.command = CMD_RESOLVE;
        b.table_index = INDEX_W'($urandom);
        b.chromosome_length = $urandom;
        b.absolute_coordinate = coord;
        b.match_length = mlen;
        beat_backlog.push_back(b);
    endfunction

    function automatic void push_resolve(longint pos, bit minus_s, logic [MLEN_W-1:0] mlen);
        push_resolve_coord(minus_s ? coord_t'(-pos) : coord_t'(pos), mlen);
    endfunction

    // let the input drain and every result arrive, then let the block settle
    task automatic wait_quiet();
        int spins;
        spins = 0;
        while (beat_backlog.size() != 0 || drv_active)
            @(posedge clk);
        while (expected_placements.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        while (expected_placements.size() != 0)
            note_failure($sformatf("missing result %s", show(expected_placements.pop_front())));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(int c);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= c[COUNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one count setting, then a mix of loads and mostly aimed resolves
    task automatic run_random_phase(int c);
        int                used;
        int                j;
        int                pick;
        longint            base;
        longint            total;
        longint            len;
        longint            off;
        longint            pos;
        longint            mlen_l;
        logic [MLEN_W-1:0] mlen;
        bit                minus_s;
        wait_quiet();
        set_count(c);
        used = (c > MAX_CHROMOSOMES) ? MAX_CHROMOSOMES : c;
        // every entry the walk can reach must hold a length
        for (int i = 0; i < used; i++)
            if (!plan_loaded[i])
                push_load(i, draw_length());
        repeat (PHASE_BEATS)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                if ($urandom_range(0, 1) == 1 && used > 0)
                    push_load($urandom_range(0, used - 1), draw_length());
                else
                    push_load($urandom_range(0, MAX_CHROMOSOMES - 1), draw_length());
            end
            else
            begin
                mlen = draw_match_length();
                mlen_l = longint'(mlen);
                minus_s = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                total = 0;
                for (int i = 0; i < used; i++)
                    total += longint'(plan_lengths[i]);
                pos = -1;
                if (pick < 75 && used > 0)
                begin
                    // aim near the edges of one entry
                    j = $urandom_range(0, used - 1);
                    base = 0;
                    for (int i = 0; i < j; i++)
                        base += longint'(plan_lengths[i]);
                    len = longint'(plan_lengths[j]);
                    off = 0;
                    if (len > 0)
                    begin
                        case ($urandom_range(0, 6))
                            0: off = 0;
                            1: off = len - 1;
                            2: off = mlen_l - 2;
                            3: off = mlen_l - 1;
                            4: off = len - mlen_l;
                            5: off = len - mlen_l + 1;
                            default: off = longint'($urandom) % len;
                        endcase
                        if (off < 0)
                            off = 0;
                        if (off > len - 1)
                            off = len - 1;
                    end
                    pos = base + off;
                end
                else if (pick < 85)
                    pos = total + $urandom_range(0, 300);
                if (pos >= 0 && pos < COORD_SPAN)
                    push_resolve(pos, minus_s, mlen);
                else
                    push_resolve_coord(coord_t'({$urandom, $urandom}), mlen);
            end
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // input driver, fed from the beat backlog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register write reaches the predictor at the same edge
            if (cfg_we)
                chrom_count = cfg_data;
            // accepted beat
            if (drv_active && item_bus.ready)
            begin
                absorb_beat(drv_beat);
                drv_active = 0;
                if ($urandom_range(0, 39) == 0)
                    drv_gaps_on = !drv_gaps_on;
                drv_wait = drv_gaps_on ? $urandom_range(0, 11) : 0;
            end
            // next beat after its gap
            if (!drv_active)
            begin
                if (drv_wait > 0)
                    drv_wait--;
                else if (beat_backlog.size() > 0)
                begin
                    drv_beat = beat_backlog.pop_front();
                    drv_active = 1;
                    item_bus.command <= drv_beat.command;
                    item_bus.table_index <= drv_beat.table_index;
                    item_bus.chromosome_length <= drv_beat.chromosome_length;
                    item_bus.absolute_coordinate <= drv_beat.absolute_coordinate;
                    item_bus.match_length <= drv_beat.match_length;
                end
            end
            item_bus.valid <= drv_active;
        end
    end

    // result monitor and sink stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (snk_ready && result_bus.valid)
            begin
                seen.status = result_bus.status;
                seen.chromosome_index = result_bus.chromosome_index;
                seen.match_start = result_bus.match_start;
                seen.minus_strand = result_bus.minus_strand;
                if (expected_placements.size() == 0)
                    note_failure($sformatf("unexpected result %s", show(seen)));
                else
                begin
                    want = expected_placements.pop_front();
                    if (seen.status !== want.status
                        || seen.chromosome_index !== want.chromosome_index
                        || seen.match_start !== want.match_start
                        || seen.minus_strand !== want.minus_strand)
                        note_failure($sformatf("expected %s got %s", show(want), show(seen)));
                end
                if ($urandom_range(0, 39) == 0)
                    snk_stalls_on = !snk_stalls_on;
                snk_stall = snk_stalls_on ? $urandom_range(0, 11) : 0;
                snk_ready = (snk_stall == 0);
            end
            else if (!snk_ready)
            begin
                if (snk_stall > 0)
                    snk_stall--;
                if (snk_stall == 0)
                    snk_ready = 1;
            end
            result_bus.ready <= snk_ready;
        end
    end

    // run limit
    initial
    begin
        #(64'd50_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        item_bus.valid = 1'b0;
        item_bus.command = CMD_LOAD;
        item_bus.table_index = '0;
        item_bus.chromosome_length = '0;
        item_bus.absolute_coordinate = '0;
        item_bus.match_length = '0;
        result_bus.ready = 1'b0;
        chrom_count = '0;
        mismatch_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty genome: every resolve is past the end, loads still land
        set_count(0);
        push_resolve(0, 0, 1);
        push_resolve(COORD_SPAN - 1, 0, 255);
        push_resolve(COORD_SPAN, 1, 8);
        push_resolve(1, 1, 1);
        push_load(0, 10);
        push_load(1, 0);
        push_load(2, 32'hFFFF_FFFF);
        push_load(3, 100);
        push_load(255, 5);
        wait_quiet();

        // four entries including a zero-length one and a full-width one
        set_count(4);
        // plus strand start of exactly zero, then one base short
        push_resolve(0, 0, 2);
        push_resolve(0, 0, 3);
        push_resolve(9, 0, 10);
        // minus strand ending on the last base, then one past it
        push_resolve(9, 1, 1);
        push_resolve(9, 1, 2);
        // zero-length entry is skipped
        push_resolve(10, 0, 1);
        // zero match length on both strands
        push_resolve(5, 0, 0);
        push_resolve(5, 1, 0);
        push_resolve(ENTRY3_BASE + 50, 0, 20);
        // just past the genome end
        push_resolve(ENTRY3_BASE + 100, 0, 1);
        // last base of the full-width entry
        push_resolve(ENTRY3_BASE - 1, 0, 255);
        push_resolve(ENTRY3_BASE - 1, 1, 1);
        push_resolve(ENTRY3_BASE - 1, 0, 0);

        // random phases over a spread of counts, above the depth included
        foreach (phase_counts[k])
            run_random_phase(phase_counts[k]);

        wait_quiet();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
